// ===== hw/rtl/ssds_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment digit scan: shared package
// Field widths, the default box side limit and the types passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package ssds_pkg;

    // Widths of the item fields
    localparam int DIM_W   = 10;
    localparam int LEFT_W  = 9;
    localparam int DIGIT_W = 4;

    // Largest box side handled; larger sides are clamped to it
    localparam int MAX_SIDE_DEF = 512;

    // Per-pixel flags held in the geometry register
    typedef struct packed {
        logic valid;
        logic pixel_on;
        logic last;
        logic w_zero;
        logic tall;
    } stage_ctl_t;

    // Classification of one box
    typedef struct packed {
        logic               recognised;
        logic [DIGIT_W-1:0] digit;
    } verdict_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ssds_geom.sv =====
// ----------------------------------------------------------------------------
// Seven-segment digit scan: input register and box geometry
// Clamps the box sides, derives half width, thirds of the height and the
// tall-box test, and holds them with the pixel in the first stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssds_geom #(
    parameter int MAX_SIDE = ssds_pkg::MAX_SIDE_DEF,
    localparam int SW = $clog2(MAX_SIDE + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       pixel_on,
    input  wire logic [ssds_pkg::DIM_W-1:0] box_width,
    input  wire logic [ssds_pkg::DIM_W-1:0] box_height,
    input  wire logic [ssds_pkg::LEFT_W-1:0] box_left,
    input  wire logic                       last_pixel,
    input  wire logic                       take,
    output ssds_pkg::stage_ctl_t            ctl,
    output logic [SW-1:0]                   s_w,
    output logic [SW-1:0]                   s_h,
    output logic [SW-1:0]                   s_half,
    output logic [SW-1:0]                   s_two_half,
    output logic [SW-1:0]                   s_third,
    output logic [SW-1:0]                   s_two_third_rows,
    output logic [SW-1:0]                   s_three_third_rows,
    output logic [SW-1:0]                   s_lower_row,
    output logic [ssds_pkg::LEFT_W-1:0]     s_left
);

    localparam int CW = (SW > ssds_pkg::DIM_W) ? SW : ssds_pkg::DIM_W;
    localparam int S  = SW + 1;
    localparam int PW = SW + S;
    localparam logic [PW-1:0] K3 = PW'((2 ** S) / 3);

    ssds_pkg::stage_ctl_t ctl_reg, ctl_next;
    logic [SW-1:0] w_reg, h_reg, half_reg, two_half_reg, third_reg;
    logic [SW-1:0] two_third_rows_reg, three_third_rows_reg, lower_row_reg;
    logic [ssds_pkg::LEFT_W-1:0] left_reg;

    logic [SW-1:0]   w_c, h_c, q_est, r_est, third, rem3, half;
    logic [PW-1:0]   prod;
    logic [SW+1:0]   w3;
    logic            tall;
    logic            accept;

    assign in_stall = ctl_reg.valid && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        w_c = (CW'(box_width) > CW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(box_width);
        h_c = (CW'(box_height) > CW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(box_height);

        // h/3 by reciprocal; the estimate is at most one short
        prod  = PW'(h_c) * K3;
        q_est = prod[PW-1:S];
        r_est = h_c - (q_est + (q_est << 1));
        if (r_est >= SW'(3))
        begin
            third = q_est + SW'(1);
            rem3  = r_est - SW'(3);
        end
        else
        begin
            third = q_est;
            rem3  = r_est;
        end

        half = w_c >> 1;
        w3   = (SW+2)'(w_c) + ((SW+2)'(w_c) << 1);
        // h/w > 2 is the same as h >= 3w for a non-zero width
        tall = (w_c != '0) && ((SW+2)'(h_c) >= w3);
    end

    always_comb
    begin
        ctl_next = ctl_reg;
        if (accept)
        begin
            ctl_next.valid    = 1'b1;
            ctl_next.pixel_on = pixel_on;
            ctl_next.last     = last_pixel;
            ctl_next.w_zero   = (w_c == '0);
            ctl_next.tall     = tall;
        end
        else if (take)
        begin
            ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w_reg                <= w_c;
            h_reg                <= h_c;
            half_reg             <= half;
            two_half_reg         <= half << 1;
            third_reg            <= third;
            two_third_rows_reg   <= third << 1;
            three_third_rows_reg <= h_c - rem3;
            // 2h/3 is twice h/3, plus one when h leaves remainder two
            lower_row_reg        <= (third << 1) + ((rem3 == SW'(2)) ? SW'(1) : SW'(0));
            left_reg             <= box_left;
        end
    end

    assign ctl                = ctl_reg;
    assign s_w                = w_reg;
    assign s_h                = h_reg;
    assign s_half             = half_reg;
    assign s_two_half         = two_half_reg;
    assign s_third            = third_reg;
    assign s_two_third_rows   = two_third_rows_reg;
    assign s_three_third_rows = three_third_rows_reg;
    assign s_lower_row        = lower_row_reg;
    assign s_left             = left_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ssds_scan.sv =====
// ----------------------------------------------------------------------------
// Seven-segment digit scan: position tracking, hit groups and result register
// Follows the raster position inside the box, collects the centre-column and
// row hits, and classifies the box into the result register on its last pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module ssds_scan #(
    parameter int MAX_SIDE = ssds_pkg::MAX_SIDE_DEF,
    localparam int SW = $clog2(MAX_SIDE + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ssds_pkg::stage_ctl_t         ctl,
    input  wire logic [SW-1:0]                s_w,
    input  wire logic [SW-1:0]                s_h,
    input  wire logic [SW-1:0]                s_half,
    input  wire logic [SW-1:0]                s_two_half,
    input  wire logic [SW-1:0]                s_third,
    input  wire logic [SW-1:0]                s_two_third_rows,
    input  wire logic [SW-1:0]                s_three_third_rows,
    input  wire logic [SW-1:0]                s_lower_row,
    input  wire logic [ssds_pkg::LEFT_W-1:0]  s_left,
    output logic                              take,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [ssds_pkg::DIGIT_W-1:0]      digit,
    output logic                              recognised,
    output logic [ssds_pkg::LEFT_W-1:0]       digit_left
);

    logic [SW-1:0] col_reg, col_next, row_reg, row_next;
    logic [2:0]    centre_reg, centre_next, centre_upd;
    logic [1:0]    upper_reg, upper_next, upper_upd;
    logic [1:0]    lower_reg, lower_next, lower_upd;
    logic [1:0]    hmask;
    logic          active;
    logic [SW-1:0] col_adv, row_adv;

    logic                          out_valid_reg, out_valid_next;
    logic [ssds_pkg::DIGIT_W-1:0]  digit_reg;
    logic                          recognised_reg;
    logic [ssds_pkg::LEFT_W-1:0]   left_reg;
    ssds_pkg::verdict_t            verdict;

    function automatic logic [1:0] ones3(input logic [2:0] v);
        ones3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
    endfunction

    function automatic ssds_pkg::verdict_t classify(
        input logic       w_zero,
        input logic       tall,
        input logic [2:0] c_hits,
        input logic [1:0] u_hits,
        input logic [1:0] l_hits
    );
        ssds_pkg::verdict_t v;
        logic [1:0] c, u, d;
        c = ones3(c_hits);
        u = ones3({1'b0, u_hits});
        d = ones3({1'b0, l_hits});
        v = '0;
        if (w_zero)
        begin
            v = '0;
        end
        else if (tall)
        begin
            v = '{recognised: 1'b1, digit: 4'd1};
        end
        else
        begin
            v.recognised = 1'b1;
            if (c == 2'd2 && u == 2'd2 && d == 2'd2)      v.digit = 4'd0;
            else if (c == 2'd1 && u == 2'd2 && d == 2'd1) v.digit = 4'd4;
            else if (c == 2'd3 && u == 2'd1 && d == 2'd2) v.digit = 4'd6;
            else if (c == 2'd1 && u == 2'd1 && d == 2'd1) v.digit = 4'd7;
            else if (c == 2'd3 && u == 2'd2 && d == 2'd2) v.digit = 4'd8;
            else if (c == 2'd3 && u == 2'd2 && d == 2'd1) v.digit = 4'd9;
            else if (c == 2'd3 && u == 2'd1 && d == 2'd1)
            begin
                // tell 2, 3 and 5 apart by which left half is lit
                case ({u_hits[0], l_hits[0]})
                    2'b00:   v.digit = 4'd3;
                    2'b01:   v.digit = 4'd2;
                    2'b10:   v.digit = 4'd5;
                    default: v = '0;
                endcase
            end
            else
            begin
                v = '0;
            end
        end
        classify = v;
    endfunction

    // A last pixel waits while the previous result is still held
    assign take = ctl.valid && (!ctl.last || !out_valid_reg || !out_stall);

    always_comb
    begin
        active = ctl.pixel_on && (row_reg < s_h) && !ctl.w_zero;

        if (col_reg < s_half)
            hmask = 2'b01;
        else if (col_reg < s_two_half)
            hmask = 2'b10;
        else
            hmask = 2'b00;

        centre_upd = centre_reg;
        upper_upd  = upper_reg;
        lower_upd  = lower_reg;
        if (active)
        begin
            if (col_reg == s_half && s_third != '0)
            begin
                if (row_reg < s_third)
                    centre_upd[0] = 1'b1;
                else if (row_reg < s_two_third_rows)
                    centre_upd[1] = 1'b1;
                else if (row_reg < s_three_third_rows)
                    centre_upd[2] = 1'b1;
            end
            if (row_reg == s_third)
                upper_upd = upper_reg | hmask;
            if (row_reg == s_lower_row)
                lower_upd = lower_reg | hmask;
        end

        // advance the raster position; the row stops at the box height
        if (ctl.w_zero || ((SW+1)'(col_reg) + (SW+1)'(1)) >= (SW+1)'(s_w))
        begin
            col_adv = '0;
            row_adv = (row_reg < s_h) ? row_reg + SW'(1) : row_reg;
        end
        else
        begin
            col_adv = col_reg + SW'(1);
            row_adv = row_reg;
        end

        verdict = classify(ctl.w_zero, ctl.tall, centre_upd, upper_upd, lower_upd);

        col_next    = col_reg;
        row_next    = row_reg;
        centre_next = centre_reg;
        upper_next  = upper_reg;
        lower_next  = lower_reg;
        if (take)
        begin
            if (ctl.last)
            begin
                col_next    = '0;
                row_next    = '0;
                centre_next = '0;
                upper_next  = '0;
                lower_next  = '0;
            end
            else
            begin
                col_next    = col_adv;
                row_next    = row_adv;
                centre_next = centre_upd;
                upper_next  = upper_upd;
                lower_next  = lower_upd;
            end
        end

        out_valid_next = (take && ctl.last) || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            centre_reg    <= '0;
            upper_reg     <= '0;
            lower_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            centre_reg    <= centre_next;
            upper_reg     <= upper_next;
            lower_reg     <= lower_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && ctl.last)
        begin
            digit_reg      <= verdict.digit;
            recognised_reg <= verdict.recognised;
            left_reg       <= s_left;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit      = digit_reg;
    assign recognised = recognised_reg;
    assign digit_left = left_reg;

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(take && ctl.last))
        else $error("result appeared without a last pixel");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && ctl.last) |=> (col_reg == '0 && row_reg == '0 && centre_reg == '0
                                && upper_reg == '0 && lower_reg == '0))
        else $error("box state not cleared after last pixel");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < SW'(MAX_SIDE))
        else $error("column position beyond largest box side");

    a_unrecognised_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !recognised_reg) |-> (digit_reg == '0))
        else $error("unrecognised result carries a non-zero digit");

endmodule

`default_nettype wire

// ===== hw/rtl/seven_segment_digit_scan_top.sv =====
// ----------------------------------------------------------------------------
// Seven-segment digit scan: top level
// Classifies one character box of binary pixels into a decimal digit.
// ----------------------------------------------------------------------------
// Pixels of a box enter in row-major order, one item per cycle, each carrying
// the box width, height and left edge; sides above MAX_SIDE are clamped. The
// first register stage holds the pixel with its box geometry (half width,
// thirds of the height from a constant reciprocal multiply); the second
// tracks the raster position and hit groups and, on the pixel flagged last,
// loads the digit, recognised flag and left edge into the result register.
// Throughput is one pixel per cycle when the input is not stalled. Input
// stalls only while a result is held by out_stall and the next box's last
// pixel is waiting in the first register.
`default_nettype none

module seven_segment_digit_scan_top #(
    parameter int MAX_SIDE = ssds_pkg::MAX_SIDE_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         pixel_on,
    input  wire logic [ssds_pkg::DIM_W-1:0]   box_width,
    input  wire logic [ssds_pkg::DIM_W-1:0]   box_height,
    input  wire logic [ssds_pkg::LEFT_W-1:0]  box_left,
    input  wire logic                         last_pixel,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [ssds_pkg::DIGIT_W-1:0]      digit,
    output logic                              recognised,
    output logic [ssds_pkg::LEFT_W-1:0]       digit_left
);

    localparam int SW = $clog2(MAX_SIDE + 1);

    ssds_pkg::stage_ctl_t        ctl;
    logic [SW-1:0]               s_w, s_h, s_half, s_two_half, s_third;
    logic [SW-1:0]               s_two_third_rows, s_three_third_rows, s_lower_row;
    logic [ssds_pkg::LEFT_W-1:0] s_left;
    logic                        take;

    ssds_geom #(
        .MAX_SIDE (MAX_SIDE)
    ) u_geom (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .pixel_on           (pixel_on),
        .box_width          (box_width),
        .box_height         (box_height),
        .box_left           (box_left),
        .last_pixel         (last_pixel),
        .take               (take),
        .ctl                (ctl),
        .s_w                (s_w),
        .s_h                (s_h),
        .s_half             (s_half),
        .s_two_half         (s_two_half),
        .s_third            (s_third),
        .s_two_third_rows   (s_two_third_rows),
        .s_three_third_rows (s_three_third_rows),
        .s_lower_row        (s_lower_row),
        .s_left             (s_left)
    );

    ssds_scan #(
        .MAX_SIDE (MAX_SIDE)
    ) u_scan (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .s_w                (s_w),
        .s_h                (s_h),
        .s_half             (s_half),
        .s_two_half         (s_two_half),
        .s_third            (s_third),
        .s_two_third_rows   (s_two_third_rows),
        .s_three_third_rows (s_three_third_rows),
        .s_lower_row        (s_lower_row),
        .s_left             (s_left),
        .take               (take),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .digit              (digit),
        .recognised         (recognised),
        .digit_left         (digit_left)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment digit scan: self-checking testbench
// Streams character boxes of binary pixels into the scanner and predicts the
// digit, recognised flag and left edge of every box from its own copy of the
// raster position and hit groups. Boxes are mostly rendered seven-segment
// glyphs with a little pixel noise, mixed with tall boxes, cut and overlong
// boxes, boxes whose width wanders, and fully random pixels. Both sides idle
// at random and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------

module testbench;

    import ssds_pkg::*;

    localparam int ITEM_TARGET    = 1950;
    localparam int BOX_TARGET     = 24;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 20;

    // Segment sets for digits 0..9, bit 0 top, 1 upper right, 2 lower right,
    // 3 bottom, 4 lower left, 5 upper left, 6 middle
    localparam logic [69:0] SEGMENT_MAP = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                           7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

    typedef struct packed {
        logic              on;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [LEFT_W-1:0] left;
        logic              last;
    } pixel_t;

    typedef struct packed {
        verdict_t          verdict;
        logic [LEFT_W-1:0] left;
    } digit_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              pixel_on   = 1'b0;
    logic [DIM_W-1:0]  box_width  = '0;
    logic [DIM_W-1:0]  box_height = '0;
    logic [LEFT_W-1:0] box_left   = '0;
    logic              last_pixel = 1'b0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [DIGIT_W-1:0] digit;
    logic              recognised;
    logic [LEFT_W-1:0] digit_left;

    pixel_t        pixel_queue[$];
    digit_result_t expected_digits[$];
    pixel_t        drive_item;

    // Predicted scanner state
    int unsigned scan_col;
    int unsigned scan_row;
    logic [2:0]  centre_hits;
    logic [1:0]  upper_hits;
    logic [1:0]  lower_hits;

    int mismatches;
    int boxes_queued;
    int results_checked;
    int quiet_cycles;

    seven_segment_digit_scan_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_on   (pixel_on),
        .box_width  (box_width),
        .box_height (box_height),
        .box_left   (box_left),
        .last_pixel (last_pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit      (digit),
        .recognised (recognised),
        .digit_left (digit_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [1:0] half_bits(input int unsigned x, input int unsigned half);
        if (x < half)
            return 2'b01;
        if (x < 2 * half)
            return 2'b10;
        return 2'b00;
    endfunction

    // Advance the predicted raster by one accepted pixel; classify on the last one
    task automatic track_pixel(input pixel_t p);
        int unsigned w, h, half, third, two_thirds, x, y, c, u, d;
        digit_result_t r;
        w = (p.width > MAX_SIDE_DEF) ? MAX_SIDE_DEF : p.width;
        h = (p.height > MAX_SIDE_DEF) ? MAX_SIDE_DEF : p.height;
        half = w / 2;
        third = h / 3;
        two_thirds = (h * 2) / 3;
        x = scan_col;
        y = scan_row;

        if (p.on && y < h && w != 0)
        begin
            if (x == half && third != 0)
            begin
                if (y < third)
                    centre_hits[0] = 1'b1;
                else if (y < 2 * third)
                    centre_hits[1] = 1'b1;
                else if (y < 3 * third)
                    centre_hits[2] = 1'b1;
            end
            if (y == third)
                upper_hits |= half_bits(x, half);
            if (y == two_thirds)
                lower_hits |= half_bits(x, half);
        end

        // hold the row counter at the box height so surplus pixels fall outside
        if (w == 0 || x + 1 >= w)
        begin
            scan_col = 0;
            if (scan_row < h)
                scan_row++;
        end
        else
            scan_col = x + 1;

        if (!p.last)
            return;

        r.left = p.left;
        r.verdict.digit = '0;
        r.verdict.recognised = 1'b0;
        if (w != 0)
        begin
            r.verdict.recognised = 1'b1;
            if (h / w > 2)
                r.verdict.digit = 4'd1;
            else
            begin
                c = $countones(centre_hits);
                u = $countones(upper_hits);
                d = $countones(lower_hits);
                case ({c[1:0], u[1:0], d[1:0]})
                    {2'd2, 2'd2, 2'd2}: r.verdict.digit = 4'd0;
                    {2'd1, 2'd2, 2'd1}: r.verdict.digit = 4'd4;
                    {2'd3, 2'd1, 2'd2}: r.verdict.digit = 4'd6;
                    {2'd1, 2'd1, 2'd1}: r.verdict.digit = 4'd7;
                    {2'd3, 2'd2, 2'd2}: r.verdict.digit = 4'd8;
                    {2'd3, 2'd2, 2'd1}: r.verdict.digit = 4'd9;
                    {2'd3, 2'd1, 2'd1}:
                        // split on which left half is lit
                        case ({upper_hits[0], lower_hits[0]})
                            2'b00:   r.verdict.digit = 4'd3;
                            2'b01:   r.verdict.digit = 4'd2;
                            2'b10:   r.verdict.digit = 4'd5;
                            default: r.verdict.recognised = 1'b0;
                        endcase
                    default: r.verdict.recognised = 1'b0;
                endcase
            end
        end
        expected_digits.push_back(r);

        scan_col = 0;
        scan_row = 0;
        centre_hits = '0;
        upper_hits = '0;
        lower_hits = '0;
    endtask

    task automatic queue_pixel(input pixel_t p);
        pixel_queue.push_back(p);
        if (p.last)
            boxes_queued++;
    endtask

    // Render a box of the given segments; cut drops trailing pixels, extra adds
    // surplus ones, wobble lets the width on single pixels stray
    task automatic queue_glyph(input logic [6:0] segs, input int w, input int h,
                               input int flip_pct, input int cut, input int extra,
                               input bit wobble);
        int total, mid, x, y, pw;
        logic [LEFT_W-1:0] left;
        logic lit;
        total = w * h - cut + extra;
        mid = h / 2;
        left = LEFT_W'($urandom_range(0, 511));
        for (int i = 0; i < total; i++)
        begin
            x = i % w;
            y = i / w;
            lit = (segs[0] && y == 0) || (segs[3] && y == h - 1) || (segs[6] && y == mid)
                || (segs[5] && x == 0 && y <= mid) || (segs[1] && x == w - 1 && y <= mid)
                || (segs[4] && x == 0 && y >= mid) || (segs[2] && x == w - 1 && y >= mid);
            if ($urandom_range(0, 99) < flip_pct)
                lit = !lit;
            pw = (wobble && $urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : w;
            queue_pixel('{lit, pw[DIM_W-1:0], h[DIM_W-1:0], left, i == total - 1});
        end
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: %s mismatch, got %0d want %0d", $time, field, got, want);
        mismatches++;
    endtask

    // Driver: predict each accepted pixel, then offer the next one after a gap
    int gap_left;
    int steady_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel_on <= 1'b0;
            box_width <= '0;
            box_height <= '0;
            box_left <= '0;
            last_pixel <= 1'b0;
            gap_left = 0;
            steady_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                track_pixel(drive_item);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 || pixel_queue.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    drive_item = pixel_queue.pop_front();
                    in_valid <= 1'b1;
                    pixel_on <= drive_item.on;
                    box_width <= drive_item.width;
                    box_height <= drive_item.height;
                    box_left <= drive_item.left;
                    last_pixel <= drive_item.last;
                    if (steady_left > 0)
                    begin
                        steady_left--;
                        gap_left = 0;
                    end
                    else
                    begin
                        case ($urandom_range(0, 99)) inside
                            [0:59]:  gap_left = 0;
                            [60:87]: gap_left = $urandom_range(1, 3);
                            [88:95]: gap_left = $urandom_range(4, 10);
                            [96:97]: gap_left = $urandom_range(20, 60);
                            default: steady_left = $urandom_range(50, 200);
                        endcase
                    end
                end
            end
        end
    end

    // Monitor: check each accepted result and drive the receiver's stall
    int  hold_left;
    int  stall_left;
    int  free_left;
    bit  hold_done;
    digit_result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            stall_left = 0;
            free_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_digits.size() == 0)
                    report_mismatch("unexpected result, digit", 16'(digit), 'x);
                else
                begin
                    want = expected_digits.pop_front();
                    if (digit !== want.verdict.digit)
                        report_mismatch("digit", 16'(digit), 16'(want.verdict.digit));
                    if (recognised !== want.verdict.recognised)
                        report_mismatch("recognised", 16'(recognised),
                                        16'(want.verdict.recognised));
                    if (digit_left !== want.left)
                        report_mismatch("digit_left", 16'(digit_left), 16'(want.left));
                end
                results_checked++;
                // hold off long enough for the block to fill and stall its input
                if (results_checked == 20 && !hold_done)
                begin
                    hold_done = 1'b1;
                    hold_left = LONG_HOLD;
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                out_stall <= 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:49]:
                    begin
                        free_left = $urandom_range(0, 8);
                        out_stall <= 1'b0;
                    end
                    [50:59]:
                    begin
                        free_left = $urandom_range(30, 120);
                        out_stall <= 1'b0;
                    end
                    [60:95]:
                    begin
                        stall_left = $urandom_range(0, 2);
                        out_stall <= 1'b1;
                    end
                    default:
                    begin
                        stall_left = $urandom_range(10, 40);
                        out_stall <= 1'b1;
                    end
                endcase
            end
        end
    end

    // Watchdog on cycles where neither side moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles++;
    end

    initial
    begin
        int sel, w, h, cut, extra, n;
        logic [3:0] glyph_digit;

        // Directed boxes: zero width, zero height, clamped sides, tall box,
        // short height, surplus pixels, changing dimensions
        queue_pixel('{1'b1, 10'd0, 10'd5, 9'd0, 1'b1});
        queue_pixel('{1'b0, 10'd0, 10'd0, 9'd0, 1'b1});
        queue_pixel('{1'b1, 10'd1023, 10'd1023, 9'd511, 1'b1});
        queue_pixel('{1'b1, 10'd513, 10'd1023, 9'd256, 1'b1});
        queue_pixel('{1'b1, 10'd512, 10'd1, 9'd1, 1'b1});
        queue_pixel('{1'b1, 10'd1, 10'd3, 9'd7, 1'b0});
        queue_pixel('{1'b1, 10'd1, 10'd3, 9'd7, 1'b0});
        queue_pixel('{1'b1, 10'd1, 10'd3, 9'd7, 1'b1});
        repeat (3)
            queue_pixel('{1'b1, 10'd2, 10'd2, 9'd200, 1'b0});
        queue_pixel('{1'b1, 10'd2, 10'd2, 9'd200, 1'b1});
        queue_pixel('{1'b1, 10'd1, 10'd1, 9'd33, 1'b0});
        queue_pixel('{1'b1, 10'd1, 10'd1, 9'd33, 1'b0});
        queue_pixel('{1'b1, 10'd1, 10'd1, 9'd33, 1'b1});
        queue_pixel('{1'b1, 10'd2, 10'd4, 9'd90, 1'b0});
        queue_pixel('{1'b0, 10'd3, 10'd4, 9'd90, 1'b0});
        queue_pixel('{1'b1, 10'd1, 10'd4, 9'd90, 1'b1});
        queue_glyph(SEGMENT_MAP[7*7 +: 7], 2, 3, 0, 0, 0, 1'b0);

        // Random boxes, mostly rendered glyphs
        while (pixel_queue.size() < ITEM_TARGET || boxes_queued < BOX_TARGET)
        begin
            sel = $urandom_range(0, 99);
            glyph_digit = 4'($urandom_range(0, 9));
            w = ($urandom_range(0, 49) == 0) ? $urandom_range(9, 24) : $urandom_range(2, 8);
            h = $urandom_range(w, 3 * w - 1);
            if (h > 40)
                h = 40;
            if (sel < 70)
                queue_glyph(SEGMENT_MAP[glyph_digit*7 +: 7], w, h,
                            ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0,
                            0, 0, 1'b0);
            else if (sel < 80)
            begin
                w = $urandom_range(1, 4);
                queue_glyph(7'($urandom_range(0, 127)), w, $urandom_range(3 * w, 3 * w + 6),
                            0, 0, 0, 1'b0);
            end
            else if (sel < 85)
                queue_glyph(7'($urandom_range(0, 127)), w, h, 0, 0, 0, 1'b0);
            else if (sel < 93)
            begin
                cut = 0;
                extra = 0;
                case ($urandom_range(0, 2))
                    0:       cut = $urandom_range(1, w * h - 1);
                    1:       extra = $urandom_range(1, 2 * w);
                    default: ;
                endcase
                queue_glyph(SEGMENT_MAP[glyph_digit*7 +: 7], w, h, 0, cut, extra,
                            cut == 0 && extra == 0);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    queue_pixel('{1'($urandom_range(0, 1)), DIM_W'($urandom_range(0, 1023)),
                                  DIM_W'($urandom_range(0, 1023)),
                                  LEFT_W'($urandom_range(0, 511)),
                                  k == n - 1 || $urandom_range(0, 3) == 0});
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || in_valid || expected_digits.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
